### design/jsc_pkg.sv
// Shared types, constants and helpers for the JPEG segment carver.
`default_nettype none
package jsc_pkg;

  // Marker and byte constants
  localparam logic [7:0]  BYTE_FF    = 8'hFF;
  localparam logic [7:0]  MARK_SOI   = 8'hD8;
  localparam logic [7:0]  MARK_APP0  = 8'hE0;
  localparam logic [7:0]  MARK_APP1  = 8'hE1;
  localparam logic [7:0]  MARK_SOS   = 8'hDA;
  localparam logic [15:0] EOI_PAIR   = 16'hFFD9;

  // Register file
  localparam int          MAX_SCAN_W     = 24;
  localparam int          SCAN_COUNT_DEF = 24;
  localparam logic [MAX_SCAN_W-1:0] MAX_SCAN_RESET = MAX_SCAN_W'(8 * 1024 * 1024);
  localparam logic        REQ_APP_RESET  = 1'b1;

  typedef enum logic {
    REG_REQUIRE_APP = 1'b0,
    REG_MAX_SCAN    = 1'b1
  } reg_idx_e;

  // Request kinds
  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_END  = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_ONGOING   = 3'd0,
    ST_SAVED     = 3'd1,
    ST_BAD_INTRO = 3'd2,
    ST_NOT_APP   = 3'd3,
    ST_SCAN_LONG = 3'd4,
    ST_PREMATURE = 3'd5
  } status_e;

  // Parser phases
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_INTRO  = 3'd1,
    PH_MARKER = 3'd2,
    PH_LENHI  = 3'd3,
    PH_LENLO  = 3'd4,
    PH_BODY   = 3'd5,
    PH_SCAN   = 3'd6
  } phase_e;

  // Up to four results come out of one item
  localparam int MAX_RES   = 4;
  localparam int RES_IDX_W = $clog2(MAX_RES);
  localparam int RES_CNT_W = $clog2(MAX_RES + 1);

  // Queue between parser and output sequencer
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] status;
  } res_t;

  // One parsed item: its results and the file number they carry
  typedef struct packed {
    res_t [MAX_RES-1:0]   res;
    logic [RES_CNT_W-1:0] count;
    logic [15:0]          file_number;
  } op_t;

  function automatic res_t mk_res(logic [7:0] b, logic v, status_e st);
    res_t r;
    r.out_byte   = b;
    r.byte_valid = v;
    r.status     = st;
    return r;
  endfunction

endpackage
`default_nettype wire

### design/jsc_if.sv
// Valid/ready channel interfaces for carver input and output items.
`default_nettype none
interface jsc_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;
  logic       first_after_soi;

  modport source (output valid, req_type, data_byte, first_after_soi, input ready);
  modport sink   (input valid, req_type, data_byte, first_after_soi, output ready);
endinterface

interface jsc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic [2:0]  status;
  logic [15:0] file_number;
  logic        last_result;

  modport source (output valid, out_byte, byte_valid, status, file_number, last_result,
                  input ready);
  modport sink   (input valid, out_byte, byte_valid, status, file_number, last_result,
                  output ready);
endinterface
`default_nettype wire

### design/jpeg_segment_carver_unit.sv
// Top level of the JPEG segment carver: parser, group queue and output sequencer.
//
//  channel   | dir | payload                                                | handshake
//  ----------+-----+--------------------------------------------------------+-------------
//  in_ch_i   | in  | req_type, data_byte, first_after_soi                   | valid/ready
//  out_ch_o  | out | out_byte, byte_valid, status, file_number, last_result | valid/ready
//  cfg_*_i   | in  | cfg_idx_i, cfg_data_i                                  | cfg_we_i
//
// The parser takes one byte per cycle while the group queue has room.
// Each result is one output item; the first marker byte of a file yields four, so
// throughput is set by the sequencer, one result per cycle while out_ch_o is ready.
// Each item passes through the group queue and the output register before out_ch_o.
// Reset is asynchronous and active low; it returns the parser to idle and the
// registers to their defaults. A stalled output fills the queue and drops in_ch_i.ready.
`default_nettype none
module jpeg_segment_carver_unit #(
  parameter int SCAN_COUNT_BITS = jsc_pkg::SCAN_COUNT_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_idx_i,
  input  wire logic [jsc_pkg::MAX_SCAN_W-1:0] cfg_data_i,
  jsc_in_if.sink                              in_ch_i,
  jsc_out_if.source                           out_ch_o
);
  import jsc_pkg::*;

  op_t  op;
  op_t  head;
  logic push;
  logic pop;
  logic full;
  logic empty;
  logic acc;

  assign in_ch_i.ready = !full;
  assign acc           = in_ch_i.valid && !full;

  jsc_front #(
    .SCAN_COUNT_BITS (SCAN_COUNT_BITS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .acc_i             (acc),
    .req_type_i        (in_ch_i.req_type),
    .data_byte_i       (in_ch_i.data_byte),
    .first_after_soi_i (in_ch_i.first_after_soi),
    .op_o              (op),
    .push_o            (push)
  );

  jsc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (op),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  jsc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_ch_o)
  );

`ifndef ASSERT_OFF
  // A pushed group holds between one and four results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (op.count != '0) && (op.count <= RES_CNT_W'(MAX_RES)))
    else $error("result group count out of range");

  // The sequencer never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !empty)
    else $error("pop from empty queue");

  // A saved file ends on the D9 byte of the end mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch_o.valid && (out_ch_o.status == ST_SAVED)) |->
      (out_ch_o.byte_valid && (out_ch_o.out_byte == 8'hD9) && out_ch_o.last_result))
    else $error("saved status without end mark byte");

  // An abandoned candidate carries no file byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch_o.valid && (out_ch_o.status == ST_PREMATURE)) |->
      (!out_ch_o.byte_valid && (out_ch_o.out_byte == 8'h00)))
    else $error("premature end result carries a byte");
`endif

endmodule
`default_nettype wire

### design/jsc_front.sv
// Parser front end: holds segment state and turns each item into a result group.
`default_nettype none
module jsc_front #(
  parameter int SCAN_COUNT_BITS = jsc_pkg::SCAN_COUNT_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_idx_i,
  input  wire logic [jsc_pkg::MAX_SCAN_W-1:0] cfg_data_i,
  input  wire logic                           acc_i,
  input  wire logic                           req_type_i,
  input  wire logic [7:0]                     data_byte_i,
  input  wire logic                           first_after_soi_i,
  output jsc_pkg::op_t                        op_o,
  output logic                                push_o
);
  import jsc_pkg::*;

  localparam int CW    = SCAN_COUNT_BITS;
  localparam int CMP_W = (CW > MAX_SCAN_W) ? CW : MAX_SCAN_W;

  logic                  cfg_app_q;
  logic [MAX_SCAN_W-1:0] cfg_max_q;

  phase_e        phase_q, phase_d;
  logic          fmp_q, fmp_d;
  logic [7:0]    marker_q, marker_d;
  logic [7:0]    lenhi_q, lenhi_d;
  logic [15:0]   body_q, body_d;
  logic [15:0]   last2_q, last2_d;
  logic [CW-1:0] scan_q, scan_d;
  logic [15:0]   filecnt_q, filecnt_d;

  phase_e        eff_phase;
  logic          fmp_eff;
  logic          start;
  logic          abort_end;
  logic          app_bad;
  logic [15:0]   seg_len;
  logic [15:0]   body_len;
  logic [15:0]   body_dec;
  logic [15:0]   last2_new;
  logic [CW-1:0] scan_inc;
  logic          scan_over;
  logic          eoi_seen;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_app_q <= REQ_APP_RESET;
      cfg_max_q <= MAX_SCAN_RESET;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_REQUIRE_APP: cfg_app_q <= cfg_data_i[0];
        REG_MAX_SCAN:    cfg_max_q <= cfg_data_i;
        default:         cfg_app_q <= cfg_app_q;
      endcase
    end
  end

  // Classify the incoming byte
  assign start     = (req_type_i == REQ_DATA) && first_after_soi_i;
  assign eff_phase = start ? PH_INTRO : phase_q;
  assign fmp_eff   = start | fmp_q;
  assign abort_end = (phase_q != PH_IDLE) && ((req_type_i == REQ_END) || start);
  assign app_bad   = cfg_app_q && (data_byte_i != MARK_APP0) && (data_byte_i != MARK_APP1);
  assign seg_len   = {lenhi_q, data_byte_i};
  assign body_len  = (seg_len < 16'd2) ? 16'd0 : seg_len - 16'd2;
  assign body_dec  = body_q - 16'd1;
  assign last2_new = {last2_q[7:0], data_byte_i};
  assign scan_inc  = (scan_q != {CW{1'b1}}) ? scan_q + CW'(1) : scan_q;
  assign scan_over = CMP_W'(scan_inc) > CMP_W'(cfg_max_q);
  assign eoi_seen  = (last2_new == EOI_PAIR);

  // Next state of the parser
  always_comb begin
    phase_d   = phase_q;
    fmp_d     = fmp_q;
    marker_d  = marker_q;
    lenhi_d   = lenhi_q;
    body_d    = body_q;
    last2_d   = last2_q;
    scan_d    = scan_q;
    filecnt_d = filecnt_q;
    if (acc_i) begin
      if (req_type_i == REQ_END) begin
        phase_d = PH_IDLE;
      end else begin
        if (start) begin
          fmp_d = 1'b1;
        end
        unique case (eff_phase)
          PH_INTRO: begin
            phase_d = (data_byte_i == BYTE_FF) ? PH_MARKER : PH_IDLE;
          end
          PH_MARKER: begin
            if (fmp_eff && app_bad) begin
              phase_d = PH_IDLE;
            end else begin
              fmp_d    = 1'b0;
              marker_d = data_byte_i;
              phase_d  = PH_LENHI;
            end
          end
          PH_LENHI: begin
            lenhi_d = data_byte_i;
            phase_d = PH_LENLO;
          end
          PH_LENLO, PH_BODY: begin
            body_d = (eff_phase == PH_LENLO) ? body_len : body_dec;
            if (body_d != 16'd0) begin
              phase_d = PH_BODY;
            end else if (marker_q == MARK_SOS) begin
              phase_d = PH_SCAN;
              last2_d = '0;
              scan_d  = '0;
            end else begin
              phase_d = PH_INTRO;
            end
          end
          PH_SCAN: begin
            last2_d = last2_new;
            scan_d  = scan_inc;
            if (scan_over) begin
              phase_d = PH_IDLE;
            end else if (eoi_seen) begin
              phase_d   = PH_IDLE;
              filecnt_d = filecnt_q + 16'd1;
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

  // Build the result group for this item
  always_comb begin
    logic [RES_CNT_W-1:0] cnt;
    cnt              = '0;
    op_o.res         = '0;
    op_o.file_number = filecnt_q;
    if (abort_end) begin
      op_o.res[cnt[RES_IDX_W-1:0]] = mk_res(8'h00, 1'b0, ST_PREMATURE);
      cnt = cnt + 1'b1;
    end
    if (req_type_i == REQ_DATA) begin
      unique case (eff_phase)
        PH_INTRO: begin
          if (data_byte_i != BYTE_FF) begin
            op_o.res[cnt[RES_IDX_W-1:0]] = mk_res(8'h00, 1'b0, ST_BAD_INTRO);
            cnt = cnt + 1'b1;
          end
        end
        PH_MARKER: begin
          if (fmp_eff && app_bad) begin
            op_o.res[cnt[RES_IDX_W-1:0]] = mk_res(8'h00, 1'b0, ST_NOT_APP);
            cnt = cnt + 1'b1;
          end else begin
            if (fmp_eff) begin
              op_o.res[cnt[RES_IDX_W-1:0]] = mk_res(BYTE_FF, 1'b1, ST_ONGOING);
              cnt = cnt + 1'b1;
              op_o.res[cnt[RES_IDX_W-1:0]] = mk_res(MARK_SOI, 1'b1, ST_ONGOING);
              cnt = cnt + 1'b1;
            end
            op_o.res[cnt[RES_IDX_W-1:0]] = mk_res(BYTE_FF, 1'b1, ST_ONGOING);
            cnt = cnt + 1'b1;
            op_o.res[cnt[RES_IDX_W-1:0]] = mk_res(data_byte_i, 1'b1, ST_ONGOING);
            cnt = cnt + 1'b1;
          end
        end
        PH_LENHI, PH_LENLO, PH_BODY: begin
          op_o.res[cnt[RES_IDX_W-1:0]] = mk_res(data_byte_i, 1'b1, ST_ONGOING);
          cnt = cnt + 1'b1;
        end
        PH_SCAN: begin
          if (scan_over) begin
            op_o.res[cnt[RES_IDX_W-1:0]] = mk_res(data_byte_i, 1'b1, ST_SCAN_LONG);
          end else if (eoi_seen) begin
            op_o.res[cnt[RES_IDX_W-1:0]] = mk_res(data_byte_i, 1'b1, ST_SAVED);
          end else begin
            op_o.res[cnt[RES_IDX_W-1:0]] = mk_res(data_byte_i, 1'b1, ST_ONGOING);
          end
          cnt = cnt + 1'b1;
        end
        default: cnt = cnt;
      endcase
    end
    op_o.count = cnt;
    push_o     = acc_i && (cnt != '0);
  end

  // Advance parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      fmp_q     <= 1'b0;
      marker_q  <= '0;
      lenhi_q   <= '0;
      body_q    <= '0;
      last2_q   <= '0;
      scan_q    <= '0;
      filecnt_q <= '0;
    end else begin
      phase_q   <= phase_d;
      fmp_q     <= fmp_d;
      marker_q  <= marker_d;
      lenhi_q   <= lenhi_d;
      body_q    <= body_d;
      last2_q   <= last2_d;
      scan_q    <= scan_d;
      filecnt_q <= filecnt_d;
    end
  end

endmodule
`default_nettype wire

### design/jsc_fifo.sv
// Short queue of result groups between the parser and the output sequencer.
`default_nettype none
module jsc_fifo (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire jsc_pkg::op_t push_data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output jsc_pkg::op_t      head_o,
  output logic              empty_o
);
  import jsc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  op_t              mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   count_q;

  assign full_o  = (count_q == (PTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem[rd_ptr_q];

  // Store pushed groups
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule
`default_nettype wire

### design/jsc_back.sv
// Output sequencer: steps through each queued group, one result item per cycle while out_o is ready.
`default_nettype none
module jsc_back (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire jsc_pkg::op_t head_i,
  input  wire logic         empty_i,
  output logic              pop_o,
  jsc_out_if.source         out_o
);
  import jsc_pkg::*;

  logic [RES_IDX_W-1:0] idx_q;
  logic                 ov_q;
  res_t                 res_q;
  logic [15:0]          fnum_q;
  logic                 last_q;
  logic                 load;
  logic                 at_last;

  assign load    = !empty_i && (!ov_q || out_o.ready);
  assign at_last = (RES_CNT_W'(idx_q) + 1'b1) == head_i.count;
  assign pop_o   = load && at_last;

  // Step through the head group
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (load) begin
        idx_q <= at_last ? '0 : idx_q + 1'b1;
        ov_q  <= 1'b1;
      end else if (out_o.ready) begin
        ov_q  <= 1'b0;
      end
    end
  end

  // Hold the output item
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= head_i.res[idx_q];
      fnum_q <= head_i.file_number;
      last_q <= at_last;
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.out_byte    = res_q.out_byte;
  assign out_o.byte_valid  = res_q.byte_valid;
  assign out_o.status      = res_q.status;
  assign out_o.file_number = fnum_q;
  assign out_o.last_result = last_q;

endmodule
`default_nettype wire
